### src/bm25_pkg.sv
package bm25_pkg;

  // field and register widths
  localparam int unsigned OCC_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned WGT_W   = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned FRAC_W  = 20;
  localparam int unsigned NUM_W   = OCC_W + WGT_W;
  localparam int unsigned LPROD_W = CFG_W + LEN_W;
  localparam int unsigned DEN_W   = LPROD_W + 1;

  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = WGT_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_K1_ONE_MINUS_B   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_K1_B_OVER_AVGLEN = 1'd1;

  // reset values: k1 = 1.2, b = 0.75, average length 1, in Q4.20
  localparam logic [CFG_W-1:0] K1_ONE_MINUS_B_RST   = 24'd314573;
  localparam logic [CFG_W-1:0] K1_B_OVER_AVGLEN_RST = 24'd943718;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic mul;
    logic load_div;
    logic div_step;
    logic acc;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

### src/bm25_if.sv
// query term channel
interface bm25_term_if;
  logic                        valid;
  logic                        ready;
  logic                        has_match;
  logic [bm25_pkg::OCC_W-1:0]  occurrences;
  logic [bm25_pkg::LEN_W-1:0]  field_length;
  logic [bm25_pkg::WGT_W-1:0]  term_weight;
  logic [bm25_pkg::WGT_W-1:0]  fallback_score;
  logic                        last_term;

  modport source (
    output valid, has_match, occurrences, field_length, term_weight, fallback_score,
           last_term,
    input  ready
  );
  modport sink (
    input  valid, has_match, occurrences, field_length, term_weight, fallback_score,
           last_term,
    output ready
  );
endinterface

// document score channel
interface bm25_score_if;
  logic                        valid;
  logic                        ready;
  logic [bm25_pkg::SUM_W-1:0]  doc_score;

  modport source (output valid, doc_score, input ready);
  modport sink (input valid, doc_score, output ready);
endinterface

// configuration write channel
interface bm25_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bm25_pkg::CFG_INDEX_W-1:0]  index;
  logic [bm25_pkg::CFG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/bm25_term_score_accumulator.sv
// BM25 term score accumulator. Each item is one query term of the current
// document; a matched term adds occurrences*weight / (occurrences + k1(1-b)
// + k1*b/avg * length) in Q16.16, a matched term with unknown occurrences
// adds its fallback score, and the item marked last_term emits the saturated
// Q24.16 document sum and clears it. Only the first MAX_TERMS terms of a
// document count. One item is in work at a time: a term that needs the
// division passes from acceptance through multiply, denominator setup, the
// 32 steps of the radix-2 restoring divider and accumulate, then returns to
// idle before the next acceptance; other terms skip the setup and divider. A
// last term then enters an emit state to hand its sum to the output register,
// waiting there while a previous result is still untaken; a pending result
// blocks new terms only during that wait. Configuration is always ready.
module bm25_term_score_accumulator #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  bm25_term_if.sink           term,
  bm25_score_if.source        score,
  bm25_cfg_if.sink            cfg
);

  bm25_pkg::dp_cmd_t    cmd;
  bm25_pkg::dp_status_t status;

  assign cfg.ready = 1'b1;

  // sequencer
  bm25_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (term.valid),
    .in_ready (term.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  bm25_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .has_match      (term.has_match),
    .occurrences    (term.occurrences),
    .field_length   (term.field_length),
    .term_weight    (term.term_weight),
    .fallback_score (term.fallback_score),
    .last_term      (term.last_term),
    .cfg_write      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (score.valid),
    .out_ready      (score.ready),
    .doc_score      (score.doc_score),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

### src/bm25_ctrl.sv
module bm25_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bm25_pkg::dp_status_t status,
  output bm25_pkg::dp_cmd_t    cmd
);

  bm25_pkg::state_t               state;
  bm25_pkg::state_t               state_next;
  logic [bm25_pkg::STEP_W-1:0]    step;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bm25_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == bm25_pkg::ST_LOAD) begin
      step <= '0;
    end else if (state == bm25_pkg::ST_DIV) begin
      step <= step + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bm25_pkg::ST_IDLE: begin
        if (in_valid) state_next = bm25_pkg::ST_MUL;
      end
      bm25_pkg::ST_MUL: begin
        state_next = status.need_div ? bm25_pkg::ST_LOAD : bm25_pkg::ST_ACC;
      end
      bm25_pkg::ST_LOAD: begin
        state_next = bm25_pkg::ST_DIV;
      end
      bm25_pkg::ST_DIV: begin
        if (step == bm25_pkg::STEP_W'(bm25_pkg::DIV_STEPS - 1)) state_next = bm25_pkg::ST_ACC;
      end
      bm25_pkg::ST_ACC: begin
        state_next = status.last ? bm25_pkg::ST_EMIT : bm25_pkg::ST_IDLE;
      end
      bm25_pkg::ST_EMIT: begin
        if (status.out_free) state_next = bm25_pkg::ST_IDLE;
      end
      default: begin
        state_next = bm25_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      bm25_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      bm25_pkg::ST_MUL:  cmd.mul      = 1'b1;
      bm25_pkg::ST_LOAD: cmd.load_div = 1'b1;
      bm25_pkg::ST_DIV:  cmd.div_step = 1'b1;
      bm25_pkg::ST_ACC:  cmd.acc      = 1'b1;
      bm25_pkg::ST_EMIT: cmd.emit     = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### src/bm25_dp.sv
module bm25_dp #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // term payload
  input  logic                             has_match,
  input  logic [bm25_pkg::OCC_W-1:0]       occurrences,
  input  logic [bm25_pkg::LEN_W-1:0]       field_length,
  input  logic [bm25_pkg::WGT_W-1:0]       term_weight,
  input  logic [bm25_pkg::WGT_W-1:0]       fallback_score,
  input  logic                             last_term,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [bm25_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bm25_pkg::CFG_W-1:0]       cfg_data,
  // result
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bm25_pkg::SUM_W-1:0]       doc_score,
  // control
  input  bm25_pkg::dp_cmd_t                cmd,
  output bm25_pkg::dp_status_t             status
);

  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  logic [bm25_pkg::CFG_W-1:0]   k1_one_minus_b;
  logic [bm25_pkg::CFG_W-1:0]   k1_b_over_avglen;

  logic                         match_q;
  logic                         last_q;
  logic                         counted_q;
  logic [bm25_pkg::OCC_W-1:0]   occ_q;
  logic [bm25_pkg::LEN_W-1:0]   len_q;
  logic [bm25_pkg::WGT_W-1:0]   weight_q;
  logic [bm25_pkg::WGT_W-1:0]   fallback_q;

  logic [bm25_pkg::NUM_W-1:0]   num;
  logic [bm25_pkg::LPROD_W-1:0] len_prod;
  logic [bm25_pkg::DEN_W-1:0]   den;
  logic [bm25_pkg::DEN_W-1:0]   rem;
  logic [bm25_pkg::WGT_W-1:0]   quo;

  logic [bm25_pkg::DEN_W:0]     trial;
  logic [bm25_pkg::DEN_W:0]     diff;
  logic                         take;

  logic [CNT_W-1:0]             term_count;
  logic [bm25_pkg::SUM_W-1:0]   score_sum;
  logic [bm25_pkg::WGT_W-1:0]   addend;
  logic [bm25_pkg::SUM_W:0]     sum_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1_one_minus_b   <= bm25_pkg::K1_ONE_MINUS_B_RST;
      k1_b_over_avglen <= bm25_pkg::K1_B_OVER_AVGLEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bm25_pkg::CFG_K1_ONE_MINUS_B:   k1_one_minus_b   <= cfg_data;
        bm25_pkg::CFG_K1_B_OVER_AVGLEN: k1_b_over_avglen <= cfg_data;
        default: begin
          k1_one_minus_b <= k1_one_minus_b;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      match_q    <= has_match;
      last_q     <= last_term;
      counted_q  <= (term_count < CNT_W'(MAX_TERMS));
      occ_q      <= occurrences;
      len_q      <= field_length;
      weight_q   <= term_weight;
      fallback_q <= fallback_score;
    end
  end

  // numerator and length term products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num      <= bm25_pkg::NUM_W'(occ_q) * bm25_pkg::NUM_W'(weight_q);
      len_prod <= bm25_pkg::LPROD_W'(k1_b_over_avglen) * bm25_pkg::LPROD_W'(len_q);
    end
  end

  // restoring divider, one quotient bit per step; upper dividend bits start as remainder
  assign trial = {rem, quo[bm25_pkg::WGT_W-1]};
  assign diff  = trial - {1'b0, den};
  assign take  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      den <= bm25_pkg::DEN_W'({occ_q, {bm25_pkg::FRAC_W{1'b0}}})
           + bm25_pkg::DEN_W'(k1_one_minus_b) + bm25_pkg::DEN_W'(len_prod);
      rem <= bm25_pkg::DEN_W'(num[bm25_pkg::NUM_W-1:bm25_pkg::WGT_W-bm25_pkg::FRAC_W]);
      quo <= {num[bm25_pkg::WGT_W-bm25_pkg::FRAC_W-1:0], {bm25_pkg::FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= take ? diff[bm25_pkg::DEN_W-1:0] : trial[bm25_pkg::DEN_W-1:0];
      quo <= {quo[bm25_pkg::WGT_W-2:0], take};
    end
  end

  assign status.need_div = counted_q & match_q & (occ_q != '0);
  assign status.last     = last_q;
  assign status.out_free = ~out_valid | out_ready;

  // term contribution and saturating sum
  always_comb begin
    if (!(counted_q & match_q)) begin
      addend = '0;
    end else if (occ_q == '0) begin
      addend = fallback_q;
    end else begin
      addend = quo;
    end
  end

  assign sum_wide = {1'b0, score_sum} + (bm25_pkg::SUM_W + 1)'(addend);

  always_ff @(posedge clk) begin
    if (rst) begin
      score_sum  <= '0;
      term_count <= '0;
    end else if (cmd.emit) begin
      score_sum  <= '0;
      term_count <= '0;
    end else if (cmd.acc) begin
      score_sum <= sum_wide[bm25_pkg::SUM_W] ? {bm25_pkg::SUM_W{1'b1}}
                                              : sum_wide[bm25_pkg::SUM_W-1:0];
      if (counted_q) term_count <= term_count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      doc_score <= score_sum;
    end
  end

endmodule
